// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the money flow RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define CMF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CMF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- hdl/cmf_pkg.sv -----
// Shared constants and control types for the money flow unit.
// No dependencies; the modules but cmf_ram use it by scoped names.
package cmf_pkg;

	// Default depth of the bar history.
	localparam int MAX_WINDOW_DEF = 64;

	// Field widths of the input and result beats.
	localparam int PRICE_W = 24;
	localparam int VOL_W   = 32;
	localparam int Q15_W   = 16;
	localparam int FVOL_W  = 33;
	localparam int N_W     = PRICE_W + 3;
	localparam int QUOT_W  = 16;

	// Stream and register port widths.
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_TUSER_W = 2;
	localparam int PADDR_W     = 3;
	localparam int APB_DATA_W  = 32;

	// Window length register.
	localparam int WL_W = 7;
	localparam logic [WL_W-1:0] WL_RESET = 7'd20;
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	// Q1.15 saturation limits.
	localparam logic [Q15_W-1:0] Q15_POS_MAX = 16'h7FFF;
	localparam logic [Q15_W-1:0] Q15_NEG_MAX = 16'h8000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic mchk;
		logic mlatch;
		logic mul;
		logic trunc;
		logic sum;
		logic rchk;
		logic rlatch;
		logic out_load;
		logic div_start;
	} cmf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic mult_skip;
		logic zero_vol;
	} cmf_sts_t;

endpackage

// ----- hdl/cmf_ram.sv -----
// Generic single write port RAM with one registered read port.
// Standalone; used for the bar history ring.
module cmf_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/cmf_div.sv -----
// Restoring divider, one quotient bit per cycle, for Q1.15 quotients.
// Depends on cmf_pkg and assert_macros.svh; requires num < 2*den.
`include "assert_macros.svh"

module cmf_div #(
	parameter int W = 38
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [W-1:0]              num,
	input  logic [W-1:0]              den,
	output logic                      done,
	output logic [cmf_pkg::QUOT_W-1:0] quot
);

	localparam int QW    = cmf_pkg::QUOT_W;
	localparam int CNT_W = $clog2(QW + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W:0]       rem_q;
	logic [W-1:0]     den_q;
	logic [QW-1:0]    quot_q;

	logic             ge;
	logic [W:0]       diff;
	logic [W:0]       rem_sel;

	// Trial subtraction for the current quotient bit.
	assign ge      = rem_q >= {1'b0, den_q};
	assign diff    = rem_q - {1'b0, den_q};
	assign rem_sel = ge ? diff : rem_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QW);
		end else if (run_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient shift.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (run_q) begin
			rem_q  <= {rem_sel[W-1:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	`CMF_ASSERT_IMPLIES(a_div_no_restart, start, !run_q, "divider restarted while busy")
	`CMF_ASSERT_IMPLIES(a_div_done_idle, done_q, !run_q, "divider done while still running")

endmodule

// ----- hdl/cmf_ctrl.sv -----
// Controller state machine that sequences one bar through the datapath.
// Depends on cmf_pkg for the command and status structs.
module cmf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cmf_pkg::cmf_sts_t sts,
	output cmf_pkg::cmf_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_MCHK  = 4'd2;
	localparam logic [3:0] S_MDIV  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_TRUNC = 4'd5;
	localparam logic [3:0] S_SUM   = 4'd6;
	localparam logic [3:0] S_RCHK  = 4'd7;
	localparam logic [3:0] S_RDIV  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_valid_q;

	// Next state and command decode.
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_nx = S_MCHK;
			end
			S_MCHK: begin
				cmd.mchk      = 1'b1;
				cmd.div_start = !sts.mult_skip;
				state_nx      = sts.mult_skip ? S_MUL : S_MDIV;
			end
			S_MDIV: begin
				if (sts.div_done) begin
					cmd.mlatch = 1'b1;
					state_nx   = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_TRUNC;
			end
			S_TRUNC: begin
				cmd.trunc = 1'b1;
				state_nx  = S_SUM;
			end
			S_SUM: begin
				cmd.sum  = 1'b1;
				state_nx = S_RCHK;
			end
			S_RCHK: begin
				cmd.rchk      = 1'b1;
				cmd.div_start = !sts.zero_vol;
				state_nx      = sts.zero_vol ? S_DONE : S_RDIV;
			end
			S_RDIV: begin
				if (sts.div_done) begin
					cmd.rlatch = 1'b1;
					state_nx   = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State register and output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/cmf_dp.sv -----
// Datapath: multiplier math, window sums over the history RAM, and ratio.
// Depends on cmf_pkg, cmf_ram, cmf_div and assert_macros.svh.
`include "assert_macros.svh"

module cmf_dp #(
	parameter int MAX_WINDOW = cmf_pkg::MAX_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cmf_pkg::cmf_cmd_t                 cmd,
	output cmf_pkg::cmf_sts_t                 sts,
	input  logic                              restart,
	input  logic [cmf_pkg::WL_W-1:0]          wl,
	input  logic [cmf_pkg::PRICE_W-1:0]       in_high,
	input  logic [cmf_pkg::PRICE_W-1:0]       in_low,
	input  logic [cmf_pkg::PRICE_W-1:0]       in_close,
	input  logic [cmf_pkg::VOL_W-1:0]         in_vol,
	output logic [cmf_pkg::Q15_W-1:0]         out_mult,
	output logic [cmf_pkg::FVOL_W-1:0]        out_fvol,
	output logic [cmf_pkg::Q15_W-1:0]         out_ratio,
	output logic                              out_full,
	output logic                              out_zero
);

	localparam int PRICE_W = cmf_pkg::PRICE_W;
	localparam int VOL_W   = cmf_pkg::VOL_W;
	localparam int Q15_W   = cmf_pkg::Q15_W;
	localparam int FVOL_W  = cmf_pkg::FVOL_W;
	localparam int N_W     = cmf_pkg::N_W;
	localparam int QUOT_W  = cmf_pkg::QUOT_W;
	localparam int WL_W    = cmf_pkg::WL_W;
	localparam int WL_MAX  = 2**WL_W - 1;
	localparam int WMAX    = (MAX_WINDOW < WL_MAX) ? MAX_WINDOW : WL_MAX;
	localparam int VSUM_W  = VOL_W + $clog2(WMAX);
	localparam int FSUM_W  = VSUM_W + 1;
	localparam int AW      = $clog2(MAX_WINDOW);
	localparam int CMP_W   = (AW + 1 > WL_W) ? AW + 1 : WL_W;
	localparam int RAM_W   = FVOL_W + VOL_W;
	localparam int PROD_W  = Q15_W + VOL_W + 1;
	localparam int RND     = 2**(Q15_W-1) - 1;

	// Clamp a quotient magnitude with sign into signed Q1.15.
	function automatic logic [Q15_W-1:0] sat_q15(input logic neg, input logic [QUOT_W-1:0] q);
		logic [Q15_W-1:0] r;
		if (neg) begin
			r = q[QUOT_W-1] ? cmf_pkg::Q15_NEG_MAX : Q15_W'(-q);
		end else begin
			r = q[QUOT_W-1] ? cmf_pkg::Q15_POS_MAX : Q15_W'(q);
		end
		return r;
	endfunction

	// Captured input beat.
	logic [PRICE_W-1:0] hi_q, lo_q, cl_q;
	logic [VOL_W-1:0]   vol_q;

	// Multiplier terms.
	logic signed [N_W-1:0]   n_q;
	logic [PRICE_W-1:0]      d_q;
	logic                    hl_q;
	logic [N_W-1:0]          n_mag;
	logic                    n_big;
	logic                    mult_neg_q;
	logic signed [Q15_W-1:0] mult_q;
	logic signed [VOL_W:0]   vol_s;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [FVOL_W-1:0] fvol_q;

	// Window state.
	logic signed [FSUM_W-1:0] fsum_q;
	logic [VSUM_W-1:0]        vsum_q;
	logic [WL_W-1:0]          bars_q;
	logic [AW-1:0]            slot_q;
	logic [FSUM_W-1:0]        fsum_mag;

	logic [CMP_W-1:0]         wl_x;
	logic [CMP_W-1:0]         len;
	logic [AW-1:0]            slot;
	logic [CMP_W-1:0]         slot_inc;
	logic                     full_now;
	logic                     full_after;
	logic [RAM_W-1:0]         rd_data;
	logic signed [FSUM_W-1:0] old_flow;
	logic [VSUM_W-1:0]        old_vol;

	// Ratio and result terms.
	logic                     ratio_neg_q;
	logic [Q15_W-1:0]         ratio_q;
	logic                     win_full_q;
	logic                     zero_q;
	logic [Q15_W-1:0]         out_mult_q;
	logic [FVOL_W-1:0]        out_fvol_q;
	logic [Q15_W-1:0]         out_ratio_q;
	logic                     out_full_q;
	logic                     out_zero_q;

	// Shared divider.
	logic [VSUM_W-1:0]        div_num;
	logic [VSUM_W-1:0]        div_den;
	logic                     div_done;
	logic [QUOT_W-1:0]        div_quot;

	// Effective window length: zero acts as one, capped at the history depth.
	assign wl_x = CMP_W'(wl);
	always_comb begin
		if (wl == '0) begin
			len = CMP_W'(1);
		end else if (wl_x > CMP_W'(MAX_WINDOW)) begin
			len = CMP_W'(MAX_WINDOW);
		end else begin
			len = wl_x;
		end
	end

	// Ring slot and fill bookkeeping.
	assign slot       = (CMP_W'(slot_q) >= len) ? '0 : slot_q;
	assign slot_inc   = CMP_W'(slot) + CMP_W'(1);
	assign full_now   = CMP_W'(bars_q) >= len;
	assign full_after = full_now || ((CMP_W'(bars_q) + CMP_W'(1)) >= len);

	// Multiplier magnitude and the overflow check against twice the range.
	assign n_mag = n_q[N_W-1] ? N_W'(-n_q) : N_W'(n_q);
	assign n_big = n_mag >= N_W'({d_q, 1'b0});

	assign fsum_mag = fsum_q[FSUM_W-1] ? FSUM_W'(-fsum_q) : FSUM_W'(fsum_q);

	assign sts.mult_skip = !hl_q || n_big;
	assign sts.zero_vol  = (vsum_q == '0);
	assign sts.div_done  = div_done;

	// Divider operands: ratio in the ratio check, multiplier otherwise.
	assign div_num = cmd.rchk ? fsum_mag[VSUM_W-1:0] : VSUM_W'(n_mag);
	assign div_den = cmd.rchk ? vsum_q : VSUM_W'(d_q);

	cmf_div #(
		.W(VSUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	cmf_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_WINDOW)
	) u_hist (
		.clk  (clk),
		.we   (cmd.sum),
		.waddr(slot),
		.wdata({fvol_q, vol_q}),
		.raddr(slot),
		.rdata(rd_data)
	);

	// Entry leaving the window, only removed once the window is full.
	assign old_flow = full_now ? FSUM_W'($signed(rd_data[RAM_W-1:VOL_W])) : '0;
	assign old_vol  = full_now ? VSUM_W'(rd_data[VOL_W-1:0]) : '0;

	// Product rounded toward zero before the Q1.15 shift.
	assign vol_s    = $signed({1'b0, vol_q});
	assign prod_rnd = prod_q + (prod_q[PROD_W-1] ? PROD_W'(RND) : PROD_W'(0));

	// Window sums and ring pointers; a window length write restarts the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsum_q <= '0;
			vsum_q <= '0;
			bars_q <= '0;
			slot_q <= '0;
		end else if (restart) begin
			fsum_q <= '0;
			vsum_q <= '0;
			bars_q <= '0;
			slot_q <= '0;
		end else if (cmd.sum) begin
			fsum_q <= fsum_q - old_flow + FSUM_W'(fvol_q);
			vsum_q <= vsum_q - old_vol + VSUM_W'(vol_q);
			bars_q <= full_now ? bars_q : bars_q + WL_W'(1);
			slot_q <= (slot_inc >= len) ? '0 : slot_inc[AW-1:0];
		end
	end

	// Per-bar arithmetic registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hi_q  <= in_high;
			lo_q  <= in_low;
			cl_q  <= in_close;
			vol_q <= in_vol;
		end
		if (cmd.prep) begin
			n_q  <= $signed(N_W'({cl_q, 1'b0}) - N_W'(lo_q) - N_W'(hi_q));
			d_q  <= hi_q - lo_q;
			hl_q <= hi_q > lo_q;
		end
		if (cmd.mchk) begin
			mult_neg_q <= n_q[N_W-1];
			if (!hl_q) begin
				mult_q <= '0;
			end else if (n_big) begin
				mult_q <= n_q[N_W-1] ? cmf_pkg::Q15_NEG_MAX : cmf_pkg::Q15_POS_MAX;
			end
		end
		if (cmd.mlatch) begin
			mult_q <= sat_q15(mult_neg_q, div_quot);
		end
		if (cmd.mul) begin
			prod_q <= mult_q * vol_s;
		end
		if (cmd.trunc) begin
			fvol_q <= prod_rnd[Q15_W-1 +: FVOL_W];
		end
		if (cmd.sum) begin
			win_full_q <= full_after;
		end
		if (cmd.rchk) begin
			ratio_neg_q <= fsum_q[FSUM_W-1];
			zero_q      <= sts.zero_vol;
			if (sts.zero_vol) begin
				ratio_q <= '0;
			end
		end
		if (cmd.rlatch) begin
			ratio_q <= sat_q15(ratio_neg_q, div_quot);
		end
		if (cmd.out_load) begin
			out_mult_q  <= mult_q;
			out_fvol_q  <= fvol_q;
			out_ratio_q <= ratio_q;
			out_full_q  <= win_full_q;
			out_zero_q  <= zero_q;
		end
	end

	assign out_mult  = out_mult_q;
	assign out_fvol  = out_fvol_q;
	assign out_ratio = out_ratio_q;
	assign out_full  = out_full_q;
	assign out_zero  = out_zero_q;

	`CMF_ASSERT_ALWAYS(a_flow_within_volume, fsum_mag <= FSUM_W'(vsum_q), "flow sum exceeds volume sum")
	`CMF_ASSERT_ALWAYS(a_bars_within_window, CMP_W'(bars_q) <= len, "bar count beyond window")

endmodule

// ----- hdl/chaikin_money_flow_unit.sv -----
// Chaikin money flow unit: one result beat for each accepted price bar.
// Each bar needs up to two divisions, either or both of which can be skipped, on the
// shared restoring divider with its 16-bit quotient. A new bar is accepted only once the
// result of the last one has been loaded for output. Reset: arst_n clears the controller,
// window sums and pointers, sets window_length to 20; the history RAM is not cleared and
// needs no clearing pass.
module chaikin_money_flow_unit #(
	parameter int MAX_WINDOW = cmf_pkg::MAX_WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Register port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cmf_pkg::PADDR_W-1:0]        paddr,
	input  logic [cmf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [cmf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	// Bars in.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// high_price[23:0], low_price[47:24], close_price[71:48], bar_volume[103:72]
	input  logic [cmf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// Results out.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// flow_multiplier[15:0], flow_volume[48:16], money_flow_ratio[64:49], zero pad
	output logic [cmf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// window_full[0], zero_volume[1]
	output logic [cmf_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

	localparam int WL_W    = cmf_pkg::WL_W;
	localparam int PRICE_W = cmf_pkg::PRICE_W;
	localparam int VOL_W   = cmf_pkg::VOL_W;
	localparam int Q15_W   = cmf_pkg::Q15_W;
	localparam int FVOL_W  = cmf_pkg::FVOL_W;
	localparam int PAD_W   = cmf_pkg::OUT_TDATA_W - 2*Q15_W - FVOL_W;

	logic [WL_W-1:0]   wl_q;
	logic              reg_sel;
	logic              cfg_wr;
	cmf_pkg::cmf_cmd_t cmd;
	cmf_pkg::cmf_sts_t sts;

	logic [Q15_W-1:0]  res_mult;
	logic [FVOL_W-1:0] res_fvol;
	logic [Q15_W-1:0]  res_ratio;
	logic              res_full;
	logic              res_zero;

	// Register decode; one register per 32-bit word.
	assign reg_sel = (paddr[2] == cmf_pkg::REG_WINDOW_LENGTH);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? cmf_pkg::APB_DATA_W'(wl_q) : '0;

	// Window length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= cmf_pkg::WL_RESET;
		end else if (cfg_wr) begin
			wl_q <= pwdata[WL_W-1:0];
		end
	end

	cmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cmf_dp #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.restart  (cfg_wr),
		.wl       (wl_q),
		.in_high  (s_axis_tdata[PRICE_W-1:0]),
		.in_low   (s_axis_tdata[2*PRICE_W-1:PRICE_W]),
		.in_close (s_axis_tdata[3*PRICE_W-1:2*PRICE_W]),
		.in_vol   (s_axis_tdata[3*PRICE_W+VOL_W-1:3*PRICE_W]),
		.out_mult (res_mult),
		.out_fvol (res_fvol),
		.out_ratio(res_ratio),
		.out_full (res_full),
		.out_zero (res_zero)
	);

	// Result beat packing.
	assign m_axis_tdata = {{PAD_W{1'b0}}, res_ratio, res_fvol, res_mult};
	assign m_axis_tuser = {res_zero, res_full};

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for chaikin_money_flow_unit: price bars go in on the input
// stream, and every result beat is checked against a local model of the window sums.
// Depends on cmf_pkg and the unit's RTL only.
module tb_top;

	localparam int PADDR_W    = cmf_pkg::PADDR_W;
	localparam int APB_DATA_W = cmf_pkg::APB_DATA_W;
	localparam int PRICE_W    = cmf_pkg::PRICE_W;
	localparam int VOL_W      = cmf_pkg::VOL_W;
	localparam int Q15_W      = cmf_pkg::Q15_W;
	localparam int FVOL_W     = cmf_pkg::FVOL_W;
	localparam int WL_W       = cmf_pkg::WL_W;

	localparam int HIST_DEPTH   = cmf_pkg::MAX_WINDOW_DEF;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int IDLE_PCT     = 21;
	localparam int MAX_GAP      = 6;
	localparam int MAX_REPORTS  = 10;
	localparam int SETTLE_CYCLES = 60;
	localparam int BARS_PER_SETTING = 150;
	localparam logic [PADDR_W-1:0] WL_ADDR    = PADDR_W'(4 * cmf_pkg::REG_WINDOW_LENGTH);
	localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);
	localparam logic [PRICE_W-1:0] PRICE_MAX  = '1;
	localparam logic [VOL_W-1:0]   VOL_MAX    = '1;
	localparam int FVOL_LSB  = Q15_W;
	localparam int RATIO_LSB = Q15_W + FVOL_W;

	// One price bar, laid out as on the input stream (high in the lowest bits).
	typedef struct packed {
		logic [VOL_W-1:0]   volume;
		logic [PRICE_W-1:0] close;
		logic [PRICE_W-1:0] low;
		logic [PRICE_W-1:0] high;
	} bar_t;

	typedef struct {
		logic signed [Q15_W-1:0]  mult;
		logic signed [FVOL_W-1:0] fvol;
		logic signed [Q15_W-1:0]  ratio;
		logic                     full;
		logic                     zvol;
	} flow_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// high_price[23:0], low_price[47:24], close_price[71:48], bar_volume[103:72]
	logic [cmf_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// flow_multiplier[15:0], flow_volume[48:16], money_flow_ratio[64:49], zero pad
	logic [cmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	// window_full[0], zero_volume[1]
	logic [cmf_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

	// Local copy of the window state and register.
	longint flow_ring [HIST_DEPTH];
	longint vol_ring [HIST_DEPTH];
	longint flow_acc;
	longint vol_acc;
	int bars_in_window;
	int next_slot;
	logic [WL_W-1:0] window_reg;

	flow_result_t pending_results[$];
	int mismatches = 0;
	longint cycles = 0;
	bit tx_no_idle = 1'b0;
	bit rx_no_stall = 1'b0;

	chaikin_money_flow_unit uut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
	);

	// Free-running 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the unit hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result-side backpressure: random stalls unless a no-stall stretch is running.
	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else if (rx_no_stall)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
	end

	function automatic void note_failure(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("mismatch: %s", msg);
		mismatches++;
	endfunction

	function automatic longint sat_q15(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic void restart_window();
		flow_acc = 0;
		vol_acc = 0;
		bars_in_window = 0;
		next_slot = 0;
	endfunction

	// Computes the result of one bar and advances the window state.
	function automatic flow_result_t flow_for_bar(input bar_t b);
		longint hi, lo, cl, vol, mult, fvol, ratio;
		int len, slot;
		flow_result_t r;
		hi = longint'(b.high);
		lo = longint'(b.low);
		cl = longint'(b.close);
		vol = longint'(b.volume);
		if (window_reg == 0)
			len = 1;
		else if (window_reg > HIST_DEPTH)
			len = HIST_DEPTH;
		else
			len = int'(window_reg);
		mult = 0;
		if (hi > lo)
			mult = sat_q15(((2 * cl - lo - hi) * 32768) / (hi - lo));
		fvol = (mult * vol) / 32768;

		// Drop the oldest bar once the window is full, then add the new one.
		slot = (next_slot >= len) ? 0 : next_slot;
		if (bars_in_window >= len) begin
			flow_acc -= flow_ring[slot];
			vol_acc -= vol_ring[slot];
		end else begin
			bars_in_window++;
		end
		flow_ring[slot] = fvol;
		vol_ring[slot] = vol;
		flow_acc += fvol;
		vol_acc += vol;
		next_slot = (slot + 1 >= len) ? 0 : slot + 1;

		ratio = (vol_acc == 0) ? 0 : sat_q15((flow_acc * 32768) / vol_acc);
		r.mult = mult[Q15_W-1:0];
		r.fvol = fvol[FVOL_W-1:0];
		r.ratio = ratio[Q15_W-1:0];
		r.full = (bars_in_window >= len);
		r.zvol = (vol_acc == 0);
		return r;
	endfunction

	// Compares each accepted result beat with the oldest pending expectation.
	always @(posedge clk) begin : result_checker
		flow_result_t want;
		logic signed [Q15_W-1:0] got_mult, got_ratio;
		logic signed [FVOL_W-1:0] got_fvol;
		logic got_full, got_zvol;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_mult = m_axis_tdata[0 +: Q15_W];
			got_fvol = m_axis_tdata[FVOL_LSB +: FVOL_W];
			got_ratio = m_axis_tdata[RATIO_LSB +: Q15_W];
			got_full = m_axis_tuser[0];
			got_zvol = m_axis_tuser[1];
			if (pending_results.size() == 0) begin
				note_failure("result beat with no bar waiting for it");
			end else begin
				want = pending_results.pop_front();
				if (want.mult !== got_mult || want.fvol !== got_fvol ||
						want.ratio !== got_ratio || want.full !== got_full ||
						want.zvol !== got_zvol)
					note_failure($sformatf(
						"mult %0d/%0d fvol %0d/%0d ratio %0d/%0d full %0b/%0b zvol %0b/%0b (exp/got)",
						want.mult, got_mult, want.fvol, got_fvol, want.ratio, got_ratio,
						want.full, got_full, want.zvol, got_zvol));
			end
		end
	end

	function automatic bar_t make_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
			input logic [PRICE_W-1:0] cl, input logic [VOL_W-1:0] vol);
		bar_t b;
		b.high = hi;
		b.low = lo;
		b.close = cl;
		b.volume = vol;
		return b;
	endfunction

	// Mostly well-formed bars of random magnitude, with some inverted, out-of-range
	// and fully random ones mixed in, and some with zero, full-scale or tiny volume.
	function automatic bar_t random_bar();
		longint lo, span, hi;
		bar_t b;
		int kind;
		kind = $urandom_range(0, 9);
		lo = longint'($urandom() >> $urandom_range(8, 31));
		span = longint'($urandom() >> $urandom_range(8, 31));
		hi = lo + span;
		if (hi > longint'(PRICE_MAX))
			hi = longint'(PRICE_MAX);
		b.low = PRICE_W'(lo);
		b.high = PRICE_W'(hi);
		b.close = (hi == lo) ? PRICE_W'(lo) : PRICE_W'(lo + ($urandom() % (hi - lo + 1)));
		b.volume = $urandom() >> $urandom_range(0, 31);
		case (kind)
			6: begin
				b.high = PRICE_W'($urandom());
				b.low = PRICE_W'($urandom());
				b.close = PRICE_W'($urandom());
				b.volume = $urandom();
			end
			7: begin
				b.high = PRICE_W'(lo);
				b.low = PRICE_W'(hi);
			end
			8: b.close = PRICE_W'($urandom());
			9: begin
				case ($urandom_range(0, 2))
					0: b.volume = '0;
					1: b.volume = VOL_MAX;
					default: b.volume = VOL_W'($urandom_range(1, 15));
				endcase
			end
			default: ;
		endcase
		return b;
	endfunction

	// Sends one bar beat; valid stays high afterwards unless the next call idles.
	task automatic send_bar(input bar_t b);
		int gap;
		gap = 0;
		if (!tx_no_idle && $urandom_range(0, 99) < IDLE_PCT)
			gap = $urandom_range(1, MAX_GAP);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(flow_for_bar(b));
	endtask

	// Stops sending and waits until every expected result has arrived.
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Register write with setup and access cycles, only ever done while idle.
	task automatic write_register(input logic [PADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] value);
		wait_results_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == WL_ADDR) begin
			window_reg = value[WL_W-1:0];
			restart_window();
		end
	endtask

	task automatic send_random_bars(input int count);
		repeat (count) send_bar(random_bar());
	endtask

	// Price and volume extremes, inverted and out-of-range bars, short and overlong windows.
	task automatic test_directed_extremes();
		write_register(WL_ADDR, 4);
		send_bar(make_bar(0, 0, 0, 0));
		send_bar(make_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, VOL_MAX));
		send_bar(make_bar(10, 20, 15, 1000));
		send_bar(make_bar(PRICE_MAX, 0, PRICE_MAX, VOL_MAX));
		send_bar(make_bar(PRICE_MAX, 0, 0, VOL_MAX));
		send_bar(make_bar(100, 50, PRICE_MAX, 1000));
		send_bar(make_bar(PRICE_MAX, PRICE_MAX - PRICE_W'(1), 0, 1));
		send_bar(make_bar(100, 0, 50, 12345));
		send_bar(make_bar(3, 0, 2, 7));
		send_bar(make_bar(1, 0, 1, VOL_MAX));
		write_register(WL_ADDR, 1);
		send_bar(make_bar(200, 100, 175, 0));
		send_bar(make_bar(200, 100, 125, 4000));
		send_bar(make_bar(0, PRICE_MAX, 0, VOL_MAX));
		write_register(WL_ADDR, 0);
		send_bar(make_bar(50, 10, 40, 0));
		send_bar(make_bar(50, 10, 40, 99));
		write_register(WL_ADDR, 127);
		send_bar(make_bar(PRICE_MAX, 0, PRICE_MAX, 1));
		send_bar(make_bar(PRICE_MAX, 0, 0, 1));
	endtask

	// A run of random bars at each of several window lengths, extremes included.
	task automatic test_window_settings();
		logic [WL_W-1:0] lengths [8];
		lengths = '{7'd1, 7'd64, 7'd127, 7'd65, 7'd2, 7'd0, 7'd20, 7'd0};
		lengths[7] = WL_W'($urandom_range(1, 127));
		foreach (lengths[i]) begin
			write_register(WL_ADDR, APB_DATA_W'(lengths[i]));
			// One setting runs with neither side idling.
			tx_no_idle = (i == 1);
			rx_no_stall = (i == 1);
			send_random_bars(BARS_PER_SETTING);
		end
		tx_no_idle = 1'b0;
		rx_no_stall = 1'b0;
	endtask

	// The sender holds off until each result has come back before the next bar.
	task automatic test_drain_between_bars();
		write_register(WL_ADDR, 5);
		repeat (40) begin
			wait_results_drained();
			send_bar(random_bar());
		end
	endtask

	// A write to an address with no register must leave the window running.
	task automatic test_spare_register();
		write_register(WL_ADDR, 8);
		send_random_bars(10);
		write_register(SPARE_ADDR, $urandom());
		send_random_bars(30);
	endtask

	// Long random run with occasional window changes.
	task automatic test_random_soak();
		repeat (3) begin
			write_register(WL_ADDR, APB_DATA_W'($urandom_range(0, 127)));
			send_random_bars(100);
		end
	endtask

	initial begin
		window_reg = cmf_pkg::WL_RESET;
		restart_window();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_window_settings();
		test_drain_between_bars();
		test_spare_register();
		test_random_soak();

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- chaikin_money_flow_unit.f -----
+incdir+hdl
hdl/cmf_pkg.sv
hdl/cmf_ram.sv
hdl/cmf_div.sv
hdl/cmf_ctrl.sv
hdl/cmf_dp.sv
hdl/chaikin_money_flow_unit.sv
tb/sv/tb_top.sv
